[rtl/core/lrasm_pkg.sv]
// shared types, constants and helpers for the lazy range add / sum / max tree
// no dependencies
package lrasm_pkg;

  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int CNT_W            = 11;
  localparam int IDX_W            = 10;
  localparam int VAL_W            = 32;
  localparam int RES_W            = 64;
  localparam int CNT_RESET        = 1024;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUM  = 2'd2;
  localparam logic [1:0] OP_MAX  = 2'd3;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_FETCH, S_EVAL, S_SMUL, S_SADD, S_SLOAD, S_ACC,
    S_PMUL, S_PWL, S_PWR, S_PCLR, S_NEXT, S_UL, S_UR, S_UW, S_RET, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_START, CMD_RD_CUR, CMD_EVAL, CMD_MUL_CHILD,
    CMD_WR_L_RD_R, CMD_WR_R, CMD_CLR_PEND, CMD_MUL_SELF, CMD_WR_SELF_ADD,
    CMD_WR_SELF_LOAD, CMD_ACCUM, CMD_PUSH_L, CMD_PUSH_R, CMD_ADV, CMD_POP,
    CMD_RD_L, CMD_CAP_L_RD_R, CMD_WR_PULL, CMD_RESULT
  } cmd_t;

  typedef struct packed {
    logic       covered;
    logic       ovl_l;
    logic       ovl_r;
    logic       pend_nz;
    logic [1:0] ph;
    logic       stk_empty;
    logic       clr_last;
    logic       reject;
    logic [1:0] op;
  } status_t;

  function automatic logic [RES_W-1:0] smax64(input logic [RES_W-1:0] a,
                                              input logic [RES_W-1:0] b);
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

endpackage

[rtl/core/lazy_range_add_sum_max_tree.sv]
// top level of the lazy range add / sum / max segment tree
// depends on lrasm_pkg, lrasm_ctrl, lrasm_dp (and lrasm_ram through it)
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | op, lo_index, hi_index, value
//  out_    | output    | out_valid/out_stall | result_value, status
//  cfg_    | input     | cfg_valid/cfg_ready | data (element count)
//
// one transaction at a time, taken only while the sequencer is idle; each visited node
// is handled in turn through the node memories' single read and write ports, so a
// wide range takes longer than a point query, and a rejected item skips the tree walk
// after reset a clearing pass over all 2*MAX_ELEMENTS node addresses zeroes the node
// memories before the first input transaction is taken; configuration is taken throughout
// a finished result waits in the output register while the next input is taken
module lazy_range_add_sum_max_tree #(
  parameter int MAX_ELEMENTS = lrasm_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          in_op,
  input  logic [lrasm_pkg::IDX_W-1:0]         in_lo_index,
  input  logic [lrasm_pkg::IDX_W-1:0]         in_hi_index,
  input  logic signed [lrasm_pkg::VAL_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [lrasm_pkg::RES_W-1:0]  out_result_value,
  output logic                                out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lrasm_pkg::CNT_W-1:0]         cfg_data
);

  lrasm_pkg::cmd_t    cmd;
  lrasm_pkg::status_t stat;

  assign cfg_ready = 1'b1;

  lrasm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrasm_dp #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .in_op       (in_op),
    .in_lo_index (in_lo_index),
    .in_hi_index (in_hi_index),
    .in_value    (in_value),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .res_value   (out_result_value),
    .res_status  (out_status)
  );

endmodule

[rtl/core/lrasm_ram.sv]
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
module lrasm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/lrasm_ctrl.sv]
// traversal sequencer for the lazy range add / sum / max tree
// depends on lrasm_pkg
module lrasm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  lrasm_pkg::status_t stat,
  output lrasm_pkg::cmd_t   cmd
);

  lrasm_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign in_stall  = (state_r != lrasm_pkg::S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lrasm_pkg::S_CLEAR: if (stat.clr_last) state_nxt = lrasm_pkg::S_IDLE;
      lrasm_pkg::S_IDLE:  if (in_valid) state_nxt = lrasm_pkg::S_CHECK;
      lrasm_pkg::S_CHECK: state_nxt = stat.reject ? lrasm_pkg::S_DONE : lrasm_pkg::S_FETCH;
      lrasm_pkg::S_FETCH: state_nxt = lrasm_pkg::S_EVAL;
      lrasm_pkg::S_EVAL: begin
        if (stat.covered) begin
          if (stat.op == lrasm_pkg::OP_LOAD) state_nxt = lrasm_pkg::S_SLOAD;
          else if (stat.op == lrasm_pkg::OP_ADD) state_nxt = lrasm_pkg::S_SMUL;
          else state_nxt = lrasm_pkg::S_ACC;
        end else if (stat.pend_nz) begin
          state_nxt = lrasm_pkg::S_PMUL;
        end else begin
          state_nxt = lrasm_pkg::S_NEXT;
        end
      end
      lrasm_pkg::S_SMUL:  state_nxt = lrasm_pkg::S_SADD;
      lrasm_pkg::S_SADD:  state_nxt = lrasm_pkg::S_RET;
      lrasm_pkg::S_SLOAD: state_nxt = lrasm_pkg::S_RET;
      lrasm_pkg::S_ACC:   state_nxt = lrasm_pkg::S_RET;
      lrasm_pkg::S_PMUL:  state_nxt = lrasm_pkg::S_PWL;
      lrasm_pkg::S_PWL:   state_nxt = lrasm_pkg::S_PWR;
      lrasm_pkg::S_PWR:   state_nxt = lrasm_pkg::S_PCLR;
      lrasm_pkg::S_PCLR:  state_nxt = lrasm_pkg::S_NEXT;
      lrasm_pkg::S_NEXT: begin
        if (stat.ph == 2'd0) begin
          if (stat.ovl_l) state_nxt = lrasm_pkg::S_FETCH;
        end else if (stat.ph == 2'd1) begin
          if (stat.ovl_r) state_nxt = lrasm_pkg::S_FETCH;
        end else if (stat.op == lrasm_pkg::OP_SUM || stat.op == lrasm_pkg::OP_MAX) begin
          state_nxt = lrasm_pkg::S_RET;
        end else begin
          state_nxt = lrasm_pkg::S_UL;
        end
      end
      lrasm_pkg::S_UL:   state_nxt = lrasm_pkg::S_UR;
      lrasm_pkg::S_UR:   state_nxt = lrasm_pkg::S_UW;
      lrasm_pkg::S_UW:   state_nxt = lrasm_pkg::S_RET;
      lrasm_pkg::S_RET:  state_nxt = stat.stk_empty ? lrasm_pkg::S_DONE : lrasm_pkg::S_NEXT;
      lrasm_pkg::S_DONE: if (out_free) state_nxt = lrasm_pkg::S_IDLE;
      default:           state_nxt = lrasm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd           = lrasm_pkg::CMD_NONE;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      lrasm_pkg::S_CLEAR: cmd = lrasm_pkg::CMD_CLEAR;
      lrasm_pkg::S_IDLE:  if (in_valid) cmd = lrasm_pkg::CMD_START;
      lrasm_pkg::S_CHECK: cmd = lrasm_pkg::CMD_NONE;
      lrasm_pkg::S_FETCH: cmd = lrasm_pkg::CMD_RD_CUR;
      lrasm_pkg::S_EVAL:  cmd = lrasm_pkg::CMD_EVAL;
      lrasm_pkg::S_SMUL:  cmd = lrasm_pkg::CMD_MUL_SELF;
      lrasm_pkg::S_SADD:  cmd = lrasm_pkg::CMD_WR_SELF_ADD;
      lrasm_pkg::S_SLOAD: cmd = lrasm_pkg::CMD_WR_SELF_LOAD;
      lrasm_pkg::S_ACC:   cmd = lrasm_pkg::CMD_ACCUM;
      lrasm_pkg::S_PMUL:  cmd = lrasm_pkg::CMD_MUL_CHILD;
      lrasm_pkg::S_PWL:   cmd = lrasm_pkg::CMD_WR_L_RD_R;
      lrasm_pkg::S_PWR:   cmd = lrasm_pkg::CMD_WR_R;
      lrasm_pkg::S_PCLR:  cmd = lrasm_pkg::CMD_CLR_PEND;
      lrasm_pkg::S_NEXT: begin
        if (stat.ph == 2'd0) begin
          cmd = stat.ovl_l ? lrasm_pkg::CMD_PUSH_L : lrasm_pkg::CMD_ADV;
        end else if (stat.ph == 2'd1) begin
          cmd = stat.ovl_r ? lrasm_pkg::CMD_PUSH_R : lrasm_pkg::CMD_ADV;
        end else begin
          cmd = lrasm_pkg::CMD_NONE;
        end
      end
      lrasm_pkg::S_UL:  cmd = lrasm_pkg::CMD_RD_L;
      lrasm_pkg::S_UR:  cmd = lrasm_pkg::CMD_CAP_L_RD_R;
      lrasm_pkg::S_UW:  cmd = lrasm_pkg::CMD_WR_PULL;
      lrasm_pkg::S_RET: if (!stat.stk_empty) cmd = lrasm_pkg::CMD_POP;
      lrasm_pkg::S_DONE: begin
        if (out_free) begin
          cmd           = lrasm_pkg::CMD_RESULT;
          out_valid_nxt = 1'b1;
        end
      end
      default: cmd = lrasm_pkg::CMD_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrasm_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/core/lrasm_dp.sv]
// datapath: node memories, traversal stack, lazy add arithmetic and accumulator
// depends on lrasm_pkg and lrasm_ram
module lrasm_dp #(
  parameter int MAX_ELEMENTS = lrasm_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  lrasm_pkg::cmd_t                   cmd,
  output lrasm_pkg::status_t                stat,
  input  logic [1:0]                        in_op,
  input  logic [lrasm_pkg::IDX_W-1:0]       in_lo_index,
  input  logic [lrasm_pkg::IDX_W-1:0]       in_hi_index,
  input  logic signed [lrasm_pkg::VAL_W-1:0] in_value,
  input  logic                              cfg_we,
  input  logic [lrasm_pkg::CNT_W-1:0]       cfg_data,
  output logic signed [lrasm_pkg::RES_W-1:0] res_value,
  output logic                              res_status
);

  localparam int DEPTH = 2 * MAX_ELEMENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = AW + 1;
  localparam int SD    = $clog2(MAX_ELEMENTS) + 1;
  localparam int SIW   = $clog2(SD);
  localparam int SPW   = $clog2(SD + 1);
  localparam int CW    = lrasm_pkg::CNT_W;
  localparam int RW    = lrasm_pkg::RES_W;
  localparam int CRST  = (MAX_ELEMENTS < lrasm_pkg::CNT_RESET) ? MAX_ELEMENTS
                                                               : lrasm_pkg::CNT_RESET;

  logic [CW-1:0]  count_r, count_nxt;
  logic [1:0]     op_r, op_nxt;
  logic [CW-1:0]  ql_r, ql_nxt, qr_r, qr_nxt;
  logic [RW-1:0]  val_r, val_nxt;
  logic [NW-1:0]  cur_node_r, cur_node_nxt;
  logic [CW-1:0]  cur_lo_r, cur_lo_nxt, cur_hi_r, cur_hi_nxt;
  logic [1:0]     cur_ph_r, cur_ph_nxt;
  logic [NW-1:0]  stk_node_r [SD];
  logic [CW-1:0]  stk_lo_r [SD];
  logic [CW-1:0]  stk_hi_r [SD];
  logic [1:0]     stk_ph_r [SD];
  logic [SPW-1:0] sp_r, sp_nxt;
  logic [RW-1:0]  d_r, d_nxt, prodl_r, prodl_nxt, prodr_r, prodr_nxt;
  logic [RW-1:0]  acc_r, acc_nxt, tmp_sum_r, tmp_sum_nxt, tmp_max_r, tmp_max_nxt;
  logic           first_r, first_nxt, reject_r, reject_nxt, rd_oor_r;
  logic [AW-1:0]  clr_r;
  logic [RW-1:0]  res_value_r, res_value_nxt;
  logic           res_status_r, res_status_nxt;

  logic           stk_push;
  logic [NW-1:0]  push_node;
  logic [CW-1:0]  push_lo, push_hi;
  logic [1:0]     push_ph;
  logic [SPW-1:0] sp_m1;

  logic [CW:0]    lohi_sum;
  logic [CW-1:0]  mid, mid_p1, len_self, lenl, lenr, last;
  logic [NW-1:0]  node_l, node_r;
  logic           covered, ovl_l, ovl_r;

  logic [RW-1:0]  sum_q, max_q, pend_q, rsum, rmax, rpend;
  logic           wen_sum, wen_max, wen_pend, wr_ok, re;
  logic [NW-1:0]  wnode, rnode;
  logic [RW-1:0]  wsum, wmax, wpend;

  assign lohi_sum = {1'b0, cur_lo_r} + {1'b0, cur_hi_r};
  assign mid      = lohi_sum[CW:1];
  assign mid_p1   = mid + CW'(1);
  assign len_self = cur_hi_r - cur_lo_r + CW'(1);
  assign lenl     = mid - cur_lo_r + CW'(1);
  assign lenr     = cur_hi_r - mid;
  assign last     = count_r - CW'(1);
  assign node_l   = {cur_node_r[NW-2:0], 1'b0};
  assign node_r   = {cur_node_r[NW-2:0], 1'b1};
  assign covered  = (ql_r <= cur_lo_r) && (cur_hi_r <= qr_r);
  assign ovl_l    = !(ql_r > mid || qr_r < cur_lo_r);
  assign ovl_r    = !(ql_r > cur_hi_r || qr_r < mid_p1);
  assign sp_m1    = sp_r - SPW'(1);

  assign rsum  = rd_oor_r ? '0 : sum_q;
  assign rmax  = rd_oor_r ? '0 : max_q;
  assign rpend = rd_oor_r ? '0 : pend_q;

  // memory port control
  always_comb begin
    wen_sum  = 1'b0;
    wen_max  = 1'b0;
    wen_pend = 1'b0;
    wnode    = cur_node_r;
    wsum     = '0;
    wmax     = '0;
    wpend    = '0;
    re       = 1'b0;
    rnode    = cur_node_r;
    case (cmd)
      lrasm_pkg::CMD_CLEAR: begin
        wen_sum  = 1'b1;
        wen_max  = 1'b1;
        wen_pend = 1'b1;
        wnode    = {1'b0, clr_r};
      end
      lrasm_pkg::CMD_RD_CUR: re = 1'b1;
      lrasm_pkg::CMD_MUL_CHILD, lrasm_pkg::CMD_RD_L: begin
        re    = 1'b1;
        rnode = node_l;
      end
      lrasm_pkg::CMD_WR_L_RD_R: begin
        wen_sum  = 1'b1;
        wen_max  = 1'b1;
        wen_pend = 1'b1;
        wnode    = node_l;
        wsum     = rsum + prodl_r;
        wmax     = rmax + d_r;
        wpend    = rpend + d_r;
        re       = 1'b1;
        rnode    = node_r;
      end
      lrasm_pkg::CMD_WR_R: begin
        wen_sum  = 1'b1;
        wen_max  = 1'b1;
        wen_pend = 1'b1;
        wnode    = node_r;
        wsum     = rsum + prodr_r;
        wmax     = rmax + d_r;
        wpend    = rpend + d_r;
      end
      lrasm_pkg::CMD_CLR_PEND: wen_pend = 1'b1;
      lrasm_pkg::CMD_WR_SELF_ADD: begin
        wen_sum  = 1'b1;
        wen_max  = 1'b1;
        wen_pend = 1'b1;
        wsum     = rsum + prodl_r;
        wmax     = rmax + val_r;
        wpend    = rpend + val_r;
      end
      lrasm_pkg::CMD_WR_SELF_LOAD: begin
        wen_sum  = 1'b1;
        wen_max  = 1'b1;
        wen_pend = 1'b1;
        wsum     = val_r;
        wmax     = val_r;
      end
      lrasm_pkg::CMD_CAP_L_RD_R: begin
        re    = 1'b1;
        rnode = node_r;
      end
      lrasm_pkg::CMD_WR_PULL: begin
        wen_sum = 1'b1;
        wen_max = 1'b1;
        wsum    = tmp_sum_r + rsum;
        wmax    = lrasm_pkg::smax64(tmp_max_r, rmax);
      end
      default: re = 1'b0;
    endcase
  end

  // nodes past the end of memory read as zero and drop writes
  assign wr_ok = (wnode < NW'(DEPTH));

  lrasm_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_sum_ram (
    .clk(clk), .we(wen_sum && wr_ok), .waddr(wnode[AW-1:0]), .wdata(wsum),
    .re(re), .raddr(rnode[AW-1:0]), .rdata(sum_q)
  );
  lrasm_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_max_ram (
    .clk(clk), .we(wen_max && wr_ok), .waddr(wnode[AW-1:0]), .wdata(wmax),
    .re(re), .raddr(rnode[AW-1:0]), .rdata(max_q)
  );
  lrasm_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_pend_ram (
    .clk(clk), .we(wen_pend && wr_ok), .waddr(wnode[AW-1:0]), .wdata(wpend),
    .re(re), .raddr(rnode[AW-1:0]), .rdata(pend_q)
  );

  // traversal registers
  always_comb begin
    count_nxt      = count_r;
    op_nxt         = op_r;
    ql_nxt         = ql_r;
    qr_nxt         = qr_r;
    val_nxt        = val_r;
    cur_node_nxt   = cur_node_r;
    cur_lo_nxt     = cur_lo_r;
    cur_hi_nxt     = cur_hi_r;
    cur_ph_nxt     = cur_ph_r;
    sp_nxt         = sp_r;
    d_nxt          = d_r;
    prodl_nxt      = prodl_r;
    prodr_nxt      = prodr_r;
    acc_nxt        = acc_r;
    tmp_sum_nxt    = tmp_sum_r;
    tmp_max_nxt    = tmp_max_r;
    first_nxt      = first_r;
    reject_nxt     = reject_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    stk_push       = 1'b0;
    push_node      = cur_node_r;
    push_lo        = cur_lo_r;
    push_hi        = cur_hi_r;
    push_ph        = 2'd1;
    if (cfg_we) begin
      count_nxt = (int'(cfg_data) > MAX_ELEMENTS) ? CW'(MAX_ELEMENTS) : cfg_data;
    end
    case (cmd)
      lrasm_pkg::CMD_START: begin
        op_nxt       = in_op;
        ql_nxt       = CW'(in_lo_index);
        qr_nxt       = (in_op == lrasm_pkg::OP_LOAD) ? CW'(in_lo_index) : CW'(in_hi_index);
        val_nxt      = {{(RW - lrasm_pkg::VAL_W){in_value[lrasm_pkg::VAL_W-1]}}, in_value};
        cur_node_nxt = NW'(1);
        cur_lo_nxt   = '0;
        cur_hi_nxt   = last;
        cur_ph_nxt   = 2'd0;
        sp_nxt       = '0;
        acc_nxt      = '0;
        first_nxt    = 1'b1;
        if (count_r == '0) begin
          reject_nxt = 1'b1;
        end else if (in_op == lrasm_pkg::OP_LOAD) begin
          reject_nxt = (CW'(in_lo_index) > last);
        end else begin
          reject_nxt = (in_lo_index > in_hi_index) || (CW'(in_hi_index) > last);
        end
      end
      lrasm_pkg::CMD_EVAL:      d_nxt = rpend;
      lrasm_pkg::CMD_MUL_CHILD: begin
        prodl_nxt = d_r * RW'(lenl);
        prodr_nxt = d_r * RW'(lenr);
      end
      lrasm_pkg::CMD_MUL_SELF:  prodl_nxt = val_r * RW'(len_self);
      lrasm_pkg::CMD_ACCUM: begin
        first_nxt = 1'b0;
        if (op_r == lrasm_pkg::OP_MAX) begin
          acc_nxt = first_r ? rmax : lrasm_pkg::smax64(acc_r, rmax);
        end else begin
          acc_nxt = acc_r + rsum;
        end
      end
      lrasm_pkg::CMD_PUSH_L: begin
        stk_push     = 1'b1;
        push_ph      = 2'd1;
        sp_nxt       = sp_r + SPW'(1);
        cur_node_nxt = node_l;
        cur_hi_nxt   = mid;
        cur_ph_nxt   = 2'd0;
      end
      lrasm_pkg::CMD_PUSH_R: begin
        stk_push     = 1'b1;
        push_ph      = 2'd2;
        sp_nxt       = sp_r + SPW'(1);
        cur_node_nxt = node_r;
        cur_lo_nxt   = mid_p1;
        cur_ph_nxt   = 2'd0;
      end
      lrasm_pkg::CMD_ADV: cur_ph_nxt = cur_ph_r + 2'd1;
      lrasm_pkg::CMD_POP: begin
        sp_nxt       = sp_m1;
        cur_node_nxt = stk_node_r[sp_m1[SIW-1:0]];
        cur_lo_nxt   = stk_lo_r[sp_m1[SIW-1:0]];
        cur_hi_nxt   = stk_hi_r[sp_m1[SIW-1:0]];
        cur_ph_nxt   = stk_ph_r[sp_m1[SIW-1:0]];
      end
      lrasm_pkg::CMD_CAP_L_RD_R: begin
        tmp_sum_nxt = rsum;
        tmp_max_nxt = rmax;
      end
      lrasm_pkg::CMD_RESULT: begin
        res_status_nxt = reject_r;
        res_value_nxt  = (!reject_r && (op_r == lrasm_pkg::OP_SUM ||
                                        op_r == lrasm_pkg::OP_MAX)) ? acc_r : '0;
      end
      default: d_nxt = d_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= CW'(CRST);
      sp_r     <= '0;
      clr_r    <= '0;
      reject_r <= 1'b0;
      rd_oor_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      sp_r     <= sp_nxt;
      reject_r <= reject_nxt;
      if (cmd == lrasm_pkg::CMD_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if (re) begin
        rd_oor_r <= (rnode >= NW'(DEPTH));
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    ql_r         <= ql_nxt;
    qr_r         <= qr_nxt;
    val_r        <= val_nxt;
    cur_node_r   <= cur_node_nxt;
    cur_lo_r     <= cur_lo_nxt;
    cur_hi_r     <= cur_hi_nxt;
    cur_ph_r     <= cur_ph_nxt;
    d_r          <= d_nxt;
    prodl_r      <= prodl_nxt;
    prodr_r      <= prodr_nxt;
    acc_r        <= acc_nxt;
    tmp_sum_r    <= tmp_sum_nxt;
    tmp_max_r    <= tmp_max_nxt;
    first_r      <= first_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    if (stk_push) begin
      stk_node_r[sp_r[SIW-1:0]] <= push_node;
      stk_lo_r[sp_r[SIW-1:0]]   <= push_lo;
      stk_hi_r[sp_r[SIW-1:0]]   <= push_hi;
      stk_ph_r[sp_r[SIW-1:0]]   <= push_ph;
    end
  end

  assign res_value  = res_value_r;
  assign res_status = res_status_r;

  assign stat.covered   = covered;
  assign stat.ovl_l     = ovl_l;
  assign stat.ovl_r     = ovl_r;
  assign stat.pend_nz   = (rpend != '0);
  assign stat.ph        = cur_ph_r;
  assign stat.stk_empty = (sp_r == '0);
  assign stat.clr_last  = (clr_r == AW'(DEPTH - 1));
  assign stat.reject    = reject_r;
  assign stat.op        = op_r;

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == lrasm_pkg::CMD_POP) |-> (sp_r != '0))
    else $error("stack pop while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == lrasm_pkg::CMD_PUSH_L || cmd == lrasm_pkg::CMD_PUSH_R) |-> (sp_r < SPW'(SD)))
    else $error("stack push while full");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == lrasm_pkg::CMD_RD_CUR) |-> (cur_lo_r <= cur_hi_r))
    else $error("node range inverted");

  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(count_r) <= MAX_ELEMENTS))
    else $error("element count above limit");

endmodule

[bench/lazy_range_add_sum_max_tree_tb.sv]
`timescale 1ns / 100ps
// self-checking bench for the lazy range add / sum / max segment tree
// drives random and directed transactions, predicts results with its own tree copy
// depends on lrasm_pkg and lazy_range_add_sum_max_tree
module lazy_range_add_sum_max_tree_tb;
  import lrasm_pkg::*;

  localparam int NODES = 2 * MAX_ELEMENTS_DEF;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct {
    logic [1:0]        op;
    logic [IDX_W-1:0]  lo;
    logic [IDX_W-1:0]  hi;
    logic [VAL_W-1:0]  value;
  } tree_op_t;

  typedef struct {
    logic [RES_W-1:0] result;
    logic             status;
  } tree_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = OP_LOAD;
  logic [IDX_W-1:0] in_lo_index = '0;
  logic [IDX_W-1:0] in_hi_index = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [RES_W-1:0] out_result_value;
  logic out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  lazy_range_add_sum_max_tree dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_lo_index(in_lo_index), .in_hi_index(in_hi_index), .in_value(in_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_result_value(out_result_value), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // shadow tree
  logic [63:0] tree_sum [NODES];
  logic [63:0] tree_max [NODES];
  logic [63:0] tree_pend [NODES];
  int unsigned elem_count;

  tree_op_t pending_ops[$];
  tree_res_t expected_res[$];
  int errors = 0;
  int accepted_in = 0;
  int accepted_out = 0;
  int rejects_seen = 0;
  int idle_cycles = 0;
  bit hold_out = 0;
  bit stim_done = 0;
  bit in_taken = 0;

  function automatic logic [63:0] node_rd(ref logic [63:0] m [NODES], input int unsigned i);
    return (i < NODES) ? m[i] : 64'd0;
  endfunction

  function automatic void node_bump(int unsigned n, int unsigned len, logic [63:0] d);
    if (n < NODES) begin
      tree_sum[n] = tree_sum[n] + d * 64'(len);
      tree_max[n] = tree_max[n] + d;
      tree_pend[n] = tree_pend[n] + d;
    end
  endfunction

  function automatic void push_pending(int unsigned n, int unsigned lo, int unsigned hi);
    logic [63:0] d;
    int unsigned mid;
    d = node_rd(tree_pend, n);
    mid = (lo + hi) / 2;
    if (d != 0) begin
      node_bump(2 * n, mid - lo + 1, d);
      node_bump(2 * n + 1, hi - mid, d);
      if (n < NODES) tree_pend[n] = '0;
    end
  endfunction

  function automatic void merge_children(int unsigned n);
    logic [63:0] a, b;
    a = node_rd(tree_max, 2 * n);
    b = node_rd(tree_max, 2 * n + 1);
    if (n < NODES) begin
      tree_sum[n] = node_rd(tree_sum, 2 * n) + node_rd(tree_sum, 2 * n + 1);
      tree_max[n] = smax64(a, b);
    end
  endfunction

  function automatic void range_add(int unsigned n, int unsigned lo, int unsigned hi,
                                    int unsigned ql, int unsigned qr, logic [63:0] d);
    int unsigned mid;
    if (ql > hi || qr < lo) return;
    if (ql <= lo && hi <= qr) begin
      node_bump(n, hi - lo + 1, d);
      return;
    end
    push_pending(n, lo, hi);
    mid = (lo + hi) / 2;
    range_add(2 * n, lo, mid, ql, qr, d);
    range_add(2 * n + 1, mid + 1, hi, ql, qr, d);
    merge_children(n);
  endfunction

  function automatic void point_load(int unsigned n, int unsigned lo, int unsigned hi,
                                     int unsigned pos, logic [63:0] v);
    int unsigned mid;
    if (lo == hi) begin
      if (n < NODES) begin
        tree_sum[n] = v;
        tree_max[n] = v;
        tree_pend[n] = '0;
      end
      return;
    end
    push_pending(n, lo, hi);
    mid = (lo + hi) / 2;
    if (pos <= mid) point_load(2 * n, lo, mid, pos, v);
    else point_load(2 * n + 1, mid + 1, hi, pos, v);
    merge_children(n);
  endfunction

  function automatic logic [63:0] range_query(int unsigned n, int unsigned lo,
                                              int unsigned hi, int unsigned ql,
                                              int unsigned qr, bit want_max);
    int unsigned mid;
    logic [63:0] a, b;
    if (ql <= lo && hi <= qr) return want_max ? node_rd(tree_max, n) : node_rd(tree_sum, n);
    push_pending(n, lo, hi);
    mid = (lo + hi) / 2;
    if (qr <= mid) return range_query(2 * n, lo, mid, ql, qr, want_max);
    if (ql > mid) return range_query(2 * n + 1, mid + 1, hi, ql, qr, want_max);
    a = range_query(2 * n, lo, mid, ql, qr, want_max);
    b = range_query(2 * n + 1, mid + 1, hi, ql, qr, want_max);
    return want_max ? smax64(a, b) : a + b;
  endfunction

  function automatic tree_res_t apply_tree_op(tree_op_t t);
    tree_res_t r;
    int unsigned last;
    logic [63:0] v;
    r.result = '0;
    r.status = 1'b0;
    v = {{32{t.value[31]}}, t.value};
    if (elem_count == 0) begin
      r.status = 1'b1;
    end else begin
      last = elem_count - 1;
      if (t.op == OP_LOAD) begin
        if (t.lo > last) r.status = 1'b1;
        else point_load(1, 0, last, t.lo, v);
      end else if (t.lo > t.hi || t.hi > last) begin
        r.status = 1'b1;
      end else if (t.op == OP_ADD) begin
        range_add(1, 0, last, t.lo, t.hi, v);
      end else begin
        r.result = range_query(1, 0, last, t.lo, t.hi, t.op == OP_MAX);
      end
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // input acceptance seen at the rising edge
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
  end

  // driver
  int unsigned in_gap = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_taken) begin
        accepted_in <= accepted_in + 1;
      end
      if (in_valid && !in_taken) begin
      end else if (in_gap != 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        tree_op_t t;
        t = pending_ops.pop_front();
        expected_res.push_back(apply_tree_op(t));
        in_valid <= 1'b1;
        in_op <= t.op;
        in_lo_index <= t.lo;
        in_hi_index <= t.hi;
        in_value <= t.value;
        in_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  int unsigned out_gap = 0;
  int unsigned hold_count = 0;
  always @(negedge clk) begin
    if (hold_out) begin
      hold_count <= hold_count + 1;
      out_stall <= 1'b1;
    end else if (out_gap != 0) begin
      out_gap <= out_gap - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      out_gap <= (($urandom_range(0, 3) == 0) ? gap_len() : 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      accepted_out <= accepted_out + 1;
      if (expected_res.size() == 0) begin
        $error("result with no transaction outstanding");
        errors = errors + 1;
      end else begin
        tree_res_t e;
        e = expected_res.pop_front();
        if (out_result_value !== e.result) begin
          $error("result_value expected %0d actual %0d", $signed(e.result), out_result_value);
          errors = errors + 1;
        end
        if (out_status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_status);
          errors = errors + 1;
        end
        if (e.status) rejects_seen <= rejects_seen + 1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_out || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void queue_op(logic [1:0] op, int unsigned lo, int unsigned hi,
                                   logic [31:0] v);
    tree_op_t t;
    t.op = op;
    t.lo = lo[IDX_W-1:0];
    t.hi = hi[IDX_W-1:0];
    t.value = v;
    pending_ops.push_back(t);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 20) - 10;
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_random(int n, int unsigned cnt);
    int unsigned lo, hi, lim;
    logic [1:0] op;
    lim = (cnt == 0) ? 1 : cnt;
    for (int i = 0; i < n; i++) begin
      op = $urandom_range(0, 3);
      if ($urandom_range(0, 9) == 0) begin
        lo = $urandom_range(0, 1023);
        hi = $urandom_range(0, 1023);
      end else begin
        lo = $urandom_range(0, lim - 1);
        hi = (($urandom_range(0, 3) == 0) ? $urandom_range(lo, lim - 1)
              : lo + $urandom_range(0, 8));
        if (hi > lim - 1) hi = lim - 1;
      end
      queue_op(op, lo, hi, rand_value());
    end
  endfunction

  task automatic drain();
    while (pending_ops.size() != 0 || expected_res.size() != 0 || in_valid)
      @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] c);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= c;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    elem_count = (c > MAX_ELEMENTS_DEF) ? MAX_ELEMENTS_DEF : c;
  endtask

  initial begin
    logic [CNT_W-1:0] counts [6] = '{11'd2047, 11'd1, 11'd0, 11'd37, 11'd5, 11'd1024};
    foreach (tree_sum[i]) begin
      tree_sum[i] = '0;
      tree_max[i] = '0;
      tree_pend[i] = '0;
    end
    elem_count = CNT_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: extremes, every operation, rejects
    queue_op(OP_LOAD, 0, 0, 32'h7fff_ffff);
    queue_op(OP_LOAD, 1023, 0, 32'h8000_0000);
    queue_op(OP_LOAD, 512, 0, 32'hffff_ffff);
    queue_op(OP_ADD, 0, 1023, 32'h7fff_ffff);
    queue_op(OP_ADD, 3, 700, 32'h8000_0000);
    queue_op(OP_SUM, 0, 1023, 0);
    queue_op(OP_MAX, 0, 1023, 0);
    queue_op(OP_SUM, 1023, 1023, 0);
    queue_op(OP_MAX, 0, 0, 0);
    queue_op(OP_MAX, 5, 600, 0);
    queue_op(OP_SUM, 10, 9, 0);
    queue_op(OP_ADD, 1023, 0, 32'd5);
    queue_op(OP_LOAD, 1023, 1023, 32'h5555_aaaa);
    queue_op(OP_SUM, 511, 513, 0);
    drain();

    // long receiver hold so the block backs up
    hold_out = 1;
    queue_random(6, elem_count);
    while (hold_count < 3000) @(posedge clk);
    hold_out = 0;
    drain();

    queue_random(300, elem_count);
    drain();
    foreach (counts[k]) begin
      write_count(counts[k]);
      queue_random((k == 5) ? 250 : 40, elem_count);
      queue_op(OP_LOAD, 1023, 0, rand_value());
      queue_op(OP_SUM, 0, 1023, 0);
      drain();
    end

    $display("covered %0d input and %0d result transactions, %0d rejected,",
             accepted_in, accepted_out, rejects_seen);
    $display("over element counts from 0 to the maximum with a long output hold");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

[filelist.f]
rtl/core/lrasm_pkg.sv
rtl/core/lrasm_ram.sv
rtl/core/lrasm_ctrl.sv
rtl/core/lrasm_dp.sv
rtl/core/lazy_range_add_sum_max_tree.sv
bench/lazy_range_add_sum_max_tree_tb.sv
